>>> sv/pbrs_pkg.sv
// ----------------------------------------------------------------------------
// Precharge bypass relay sequencer package
// Shared codes, types and reset constants for the relay sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pbrs_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int CFG_INDEX_WIDTH = 1;

  localparam logic [CFG_DATA_WIDTH-1:0] PRECHARGE_TICKS_RST = 16'd1000;
  localparam logic [CFG_DATA_WIDTH-1:0] BYPASS_TICKS_RST    = 16'd1000;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRECHARGE_TICKS = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BYPASS_TICKS    = 1'b1;

  typedef enum logic [1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_CONNECT    = 2'd1,
    FUNC_DISCONNECT = 2'd2,
    FUNC_FORCE_OFF  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    PH_OFF       = 2'd0,
    PH_PRECHARGE = 2'd1,
    PH_BYPASS    = 2'd2,
    PH_CONNECTED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    UPD_NONE     = 2'd0,
    UPD_DETECTED = 2'd1,
    UPD_AUTH     = 2'd2,
    UPD_IDLE     = 2'd3
  } upd_t;

endpackage

`default_nettype wire

>>> sv/precharge_bypass_relay_sequencer_top.sv
// ----------------------------------------------------------------------------
// Precharge bypass relay sequencer
// Sequences the precharge and bypass relays on connect, disconnect, force-off
// and tick words, and reports one status word per input word.
// ----------------------------------------------------------------------------
// Usage: each input word (func and the module status bits) is taken when
// in_valid and in_ready are both high, and exactly one result word follows
// on the output channel, valid in the cycle after acceptance. A new input word
// can be taken every cycle; the output register decouples the two channels,
// so in_ready stays high while the held result is being taken in the same
// cycle. When the receiver stalls, the result word holds and in_ready drops
// until it is taken. The phase lengths are written through the cfg channel (index
// 0 precharge ticks, index 1 bypass settle ticks), which is always ready; the user
// must make writes only while the block is idle, which the block does not enforce.
// Reset puts the sequencer in the off phase with the countdown cleared, no
// disconnect pending, both phase lengths at 1000 ticks and the output channel empty.
// ----------------------------------------------------------------------------
`default_nettype none

module precharge_bypass_relay_sequencer_top #(
  parameter int TIMER_WIDTH = pbrs_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pbrs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [pbrs_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           func,
  input  wire logic                                 detect,
  input  wire logic                                 module_is_type_b,
  input  wire logic                                 module_accepted,
  input  wire logic                                 system_active,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      precharge_relay,
  output logic                                      bypass_relay,
  output logic                                      peltier_on,
  output logic [1:0]                                sequence_state,
  output logic [1:0]                                system_state_update,
  output logic                                      attach_event,
  output logic                                      detach_event,
  output logic                                      request_accepted
);

  localparam int CfgW  = pbrs_pkg::CFG_DATA_WIDTH;
  localparam int WideW = (TIMER_WIDTH > CfgW) ? TIMER_WIDTH : CfgW;
  localparam logic [WideW-1:0] TimerMax = WideW'({TIMER_WIDTH{1'b1}});

  logic [CfgW-1:0]        precharge_ticks;
  logic [CfgW-1:0]        bypass_settle_ticks;
  pbrs_pkg::phase_t       phase;
  pbrs_pkg::phase_t       phase_next;
  logic [TIMER_WIDTH-1:0] countdown;
  logic [TIMER_WIDTH-1:0] countdown_next;
  logic                   disconnect_pending;
  logic                   disconnect_pending_next;

  pbrs_pkg::func_t        fn;
  pbrs_pkg::upd_t         upd;
  pbrs_pkg::upd_t         upd_open;
  logic                   attach;
  logic                   detach;
  logic                   taken;
  logic                   in_seq;
  logic                   pend_fire;
  logic [TIMER_WIDTH-1:0] count_dec;
  logic                   expired;
  logic [WideW-1:0]       pre_wide;
  logic [WideW-1:0]       byp_wide;
  logic [TIMER_WIDTH-1:0] pre_load;
  logic [TIMER_WIDTH-1:0] byp_load;
  logic                   in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      precharge_ticks     <= pbrs_pkg::PRECHARGE_TICKS_RST;
      bypass_settle_ticks <= pbrs_pkg::BYPASS_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pbrs_pkg::REG_PRECHARGE_TICKS: precharge_ticks     <= cfg_data;
        pbrs_pkg::REG_BYPASS_TICKS:    bypass_settle_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Phase lengths saturate to the countdown width.
  assign pre_wide = WideW'(precharge_ticks);
  assign byp_wide = WideW'(bypass_settle_ticks);
  assign pre_load = (pre_wide > TimerMax) ? {TIMER_WIDTH{1'b1}} : pre_wide[TIMER_WIDTH-1:0];
  assign byp_load = (byp_wide > TimerMax) ? {TIMER_WIDTH{1'b1}} : byp_wide[TIMER_WIDTH-1:0];

  assign fn        = pbrs_pkg::func_t'(func);
  assign in_seq    = (phase == pbrs_pkg::PH_PRECHARGE) || (phase == pbrs_pkg::PH_BYPASS);
  assign pend_fire = disconnect_pending && !in_seq;
  assign count_dec = (countdown != '0) ? countdown - 1'b1 : countdown;
  assign expired   = (count_dec == '0);
  assign upd_open  = detect ? pbrs_pkg::UPD_DETECTED : pbrs_pkg::UPD_IDLE;

  always_comb begin
    phase_next              = phase;
    countdown_next          = countdown;
    disconnect_pending_next = disconnect_pending;
    if (fn == pbrs_pkg::FUNC_FORCE_OFF) begin
      phase_next              = pbrs_pkg::PH_OFF;
      countdown_next          = '0;
      disconnect_pending_next = 1'b0;
    end else if (pend_fire) begin
      phase_next              = pbrs_pkg::PH_OFF;
      countdown_next          = '0;
      disconnect_pending_next = 1'b0;
    end else if (fn == pbrs_pkg::FUNC_CONNECT) begin
      if (phase == pbrs_pkg::PH_OFF) begin
        if (detect) begin
          phase_next     = pbrs_pkg::PH_PRECHARGE;
          countdown_next = pre_load;
        end else begin
          countdown_next = '0;
        end
      end
    end else if (fn == pbrs_pkg::FUNC_DISCONNECT) begin
      if (in_seq) begin
        disconnect_pending_next = 1'b1;
      end else begin
        phase_next     = pbrs_pkg::PH_OFF;
        countdown_next = '0;
      end
    end else if (in_seq) begin
      countdown_next = count_dec;
      if (expired) begin
        if (!detect) begin
          phase_next     = pbrs_pkg::PH_OFF;
          countdown_next = '0;
        end else if (phase == pbrs_pkg::PH_PRECHARGE) begin
          phase_next     = pbrs_pkg::PH_BYPASS;
          countdown_next = byp_load;
        end else begin
          phase_next     = pbrs_pkg::PH_CONNECTED;
          countdown_next = '0;
        end
      end
    end
  end

  always_comb begin
    upd    = pbrs_pkg::UPD_NONE;
    attach = 1'b0;
    detach = 1'b0;
    taken  = 1'b0;
    if (fn == pbrs_pkg::FUNC_FORCE_OFF) begin
      upd    = upd_open;
      detach = 1'b1;
    end else if (pend_fire) begin
      upd    = upd_open;
      detach = 1'b1;
      taken  = (fn == pbrs_pkg::FUNC_DISCONNECT);
    end else if (fn == pbrs_pkg::FUNC_CONNECT) begin
      if (phase == pbrs_pkg::PH_CONNECTED) begin
        upd    = pbrs_pkg::UPD_AUTH;
        attach = 1'b1;
        taken  = 1'b1;
      end else if (phase == pbrs_pkg::PH_OFF) begin
        taken = 1'b1;
        if (detect) begin
          upd = pbrs_pkg::UPD_DETECTED;
        end else begin
          upd    = upd_open;
          detach = 1'b1;
        end
      end
    end else if (fn == pbrs_pkg::FUNC_DISCONNECT) begin
      taken = 1'b1;
      if (!in_seq) begin
        upd    = upd_open;
        detach = 1'b1;
      end
    end else if (in_seq && expired) begin
      if (!detect) begin
        upd    = upd_open;
        detach = 1'b1;
      end else if (phase == pbrs_pkg::PH_BYPASS) begin
        upd    = pbrs_pkg::UPD_AUTH;
        attach = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= pbrs_pkg::PH_OFF;
      countdown          <= '0;
      disconnect_pending <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (in_accept) begin
        phase              <= phase_next;
        countdown          <= countdown_next;
        disconnect_pending <= disconnect_pending_next;
        out_valid          <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      precharge_relay     <= (phase_next == pbrs_pkg::PH_PRECHARGE) ||
                             (phase_next == pbrs_pkg::PH_BYPASS);
      bypass_relay        <= (phase_next == pbrs_pkg::PH_BYPASS) ||
                             (phase_next == pbrs_pkg::PH_CONNECTED);
      peltier_on          <= (phase_next == pbrs_pkg::PH_CONNECTED) && module_is_type_b &&
                             module_accepted && system_active;
      sequence_state      <= phase_next;
      system_state_update <= upd;
      attach_event        <= attach;
      detach_event        <= detach;
      request_accepted    <= taken;
    end
  end

`ifndef SYNTHESIS
  a_no_count_outside_seq: assert property (@(posedge clk) disable iff (rst)
    ((phase == pbrs_pkg::PH_OFF) || (phase == pbrs_pkg::PH_CONNECTED)) |-> (countdown == '0))
    else $error("countdown is nonzero outside the timed phases");

  a_attach_detach_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(attach_event && detach_event))
    else $error("attach and detach reported in the same word");

  a_detach_means_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && detach_event) |-> (sequence_state == pbrs_pkg::PH_OFF))
    else $error("detach reported while relays stay closed");

  a_connect_only_via_bypass: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (phase_next == pbrs_pkg::PH_CONNECTED) && (phase != pbrs_pkg::PH_CONNECTED))
    |-> (phase == pbrs_pkg::PH_BYPASS))
    else $error("connected phase entered without passing bypass");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> ($stable(phase) && $stable(countdown)))
    else $error("sequencer state moved without an input word");
`endif

endmodule

`default_nettype wire
